[src/etl_pkg.sv]
// Shared types and constants for the equation token lexer.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

    localparam int MANT_W     = 32;            // digit accumulator width
    localparam int FRAC_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int DATA_W     = ((MANT_W + FRAC_W + 2 + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] SCALE_MAX = {FRAC_W{1'b1}};
    localparam logic [MANT_W-1:0] MANT_MAX  = {MANT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [KIND_W-1:0] {
        TK_ADD = 3'd0,
        TK_SUB = 3'd1,
        TK_MUL = 3'd2,
        TK_POW = 3'd3,
        TK_VAR = 3'd4,
        TK_NUM = 3'd5,
        TK_VOID = 3'd6,
        TK_EQ  = 3'd7
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [MANT_W-1:0]  mant;
        logic [FRAC_W-1:0]  frac;
        logic               ovf;
        logic               last_item;
        logic               last_text;
    } tok_t;

    // tokens produced by one character, tok0 first
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } lex_out_t;

endpackage

`default_nettype wire

[src/etl_lex_core.sv]
// Character input register, number accumulator state and token decode.
// Depends on etl_pkg; feeds etl_tok_fifo.
`timescale 1ns / 1ps
`default_nettype none

module etl_lex_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [etl_pkg::CHAR_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       ml_en,
    input  wire logic                       room,
    output etl_pkg::lex_out_t               lex_out
);
    import etl_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              end_reg;

    logic              in_number_reg, in_number_next;
    logic [MANT_W-1:0] accum_reg, accum_next;
    logic              point_reg, point_next;
    logic [FRAC_W-1:0] scale_reg, scale_next;
    logic              ovf_reg, ovf_next;
    logic              after_eq_reg, after_eq_next;

    logic              fire;
    logic              digit_ch, is_div, num_path;
    logic [MANT_W-1:0] b_accum;
    logic              b_point;
    logic [FRAC_W-1:0] b_scale;
    logic              b_ovf;
    logic [MANT_W+3:0] prod;
    tok_kind_t         raw_kind, op_kind;
    tok_t              num_tok, op_tok;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    assign digit_ch = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_div   = (char_reg == CH_DOT) || (char_reg == CH_COMMA);
    assign num_path = digit_ch || (is_div && in_number_reg);

    always_comb
    begin
        case (char_reg)
            CH_PLUS:  raw_kind = TK_ADD;
            CH_MINUS: raw_kind = TK_SUB;
            CH_STAR:  raw_kind = TK_MUL;
            CH_CARET: raw_kind = TK_POW;
            CH_EQ:    raw_kind = TK_EQ;
            CH_X:     raw_kind = TK_VAR;
            default:  raw_kind = TK_VOID;
        endcase
    end

    // move-left: '=' turns into subtract, later signs swap
    always_comb
    begin
        op_kind = raw_kind;
        if (ml_en)
        begin
            if (raw_kind == TK_EQ)
                op_kind = TK_SUB;
            else if (after_eq_reg && raw_kind == TK_ADD)
                op_kind = TK_SUB;
            else if (after_eq_reg && raw_kind == TK_SUB)
                op_kind = TK_ADD;
        end
    end

    // number state after this character; fresh number starts from zero
    always_comb
    begin
        b_accum = in_number_reg ? accum_reg : '0;
        b_point = in_number_reg && point_reg;
        b_scale = in_number_reg ? scale_reg : '0;
        b_ovf   = in_number_reg && ovf_reg;
        prod    = {1'b0, b_accum, 3'b000} + {3'b000, b_accum, 1'b0}
                  + (MANT_W + 4)'(char_reg[3:0]);
        if (b_point)
        begin
            if (b_scale < SCALE_MAX)
                b_scale = b_scale + 1'b1;
            else
                b_ovf = 1'b1;
        end
        if (is_div)
            b_point = 1'b1;
        else if (prod[MANT_W+3:MANT_W] != 4'd0)
        begin
            b_accum = MANT_MAX;
            b_ovf   = 1'b1;
        end
        else
            b_accum = prod[MANT_W-1:0];
    end

    always_comb
    begin
        num_tok.kind      = TK_NUM;
        num_tok.mant      = num_path ? b_accum : accum_reg;
        num_tok.frac      = num_path ? b_scale : scale_reg;
        num_tok.ovf       = num_path ? b_ovf : ovf_reg;
        num_tok.last_item = 1'b1;
        num_tok.last_text = end_reg;
        op_tok.kind       = op_kind;
        op_tok.mant       = MANT_W'(1);
        op_tok.frac       = '0;
        op_tok.ovf        = 1'b0;
        op_tok.last_item  = 1'b1;
        op_tok.last_text  = end_reg;

        lex_out.tok1 = op_tok;
        if (num_path)
        begin
            lex_out.tok0  = num_tok;
            lex_out.count = end_reg ? 2'd1 : 2'd0;
        end
        else if (in_number_reg)
        begin
            lex_out.tok0           = num_tok;
            lex_out.tok0.last_item = 1'b0;
            lex_out.tok0.last_text = 1'b0;
            lex_out.count          = 2'd2;
        end
        else
        begin
            lex_out.tok0  = op_tok;
            lex_out.count = 2'd1;
        end
        if (!fire)
            lex_out.count = 2'd0;
    end

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        in_number_next = in_number_reg;
        accum_next     = accum_reg;
        point_next     = point_reg;
        scale_next     = scale_reg;
        ovf_next       = ovf_reg;
        after_eq_next  = after_eq_reg;
        if (fire)
        begin
            if (num_path && !end_reg)
            begin
                in_number_next = 1'b1;
                accum_next     = b_accum;
                point_next     = b_point;
                scale_next     = b_scale;
                ovf_next       = b_ovf;
            end
            else
            begin
                in_number_next = 1'b0;
                accum_next     = '0;
                point_next     = 1'b0;
                scale_next     = '0;
                ovf_next       = 1'b0;
            end
            if (end_reg)
                after_eq_next = 1'b0;
            else if (!num_path && ml_en && raw_kind == TK_EQ)
                after_eq_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_number_reg <= 1'b0;
            accum_reg     <= '0;
            point_reg     <= 1'b0;
            scale_reg     <= '0;
            ovf_reg       <= 1'b0;
            after_eq_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            in_number_reg <= in_number_next;
            accum_reg     <= accum_next;
            point_reg     <= point_next;
            scale_reg     <= scale_next;
            ovf_reg       <= ovf_next;
            after_eq_reg  <= after_eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
    end

endmodule

`default_nettype wire

[src/etl_tok_fifo.sv]
// Four-entry token queue; takes zero, one or two tokens a cycle, gives one while m_tready is high.
// Depends on etl_pkg; driven by etl_lex_core.
`timescale 1ns / 1ps
`default_nettype none

module etl_tok_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  etl_pkg::lex_out_t        lex_in,
    output logic                     room,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output etl_pkg::tok_t            m_tok
);
    import etl_pkg::*;

    tok_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign m_tvalid  = (count_reg != '0);
    assign pop       = m_tvalid && m_tready;
    assign m_tok     = mem_reg[rd_ptr_reg];
    // room for a two-token word regardless of the reader
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(lex_in.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(lex_in.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lex_in.count != 2'd0)
            mem_reg[wr_ptr_reg] <= lex_in.tok0;
        if (lex_in.count == 2'd2)
            mem_reg[wr_ptr_p1] <= lex_in.tok1;
    end

endmodule

`default_nettype wire

[src/equation_token_lexer.sv]
// Top level of the equation token lexer: config register, lexer core, token queue.
// Depends on etl_pkg, etl_lex_core and etl_tok_fifo.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | tdata char_code, tlast text_end
//   m_      | out | m_tvalid/m_tready  | tuser token_kind, tdata token fields, tlast
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_data move-left enable
//
// One character per cycle while the token queue has room; a taken character is registered,
// and its tokens are written into the queue as it leaves the input register.
// A character that ends a number without being part of it gives two tokens and takes two queue slots;
// input stalls when the token queue has fewer than two free entries.
// Reset (rst_n, async) empties the queue and clears number state; move-left resets to 1.
`timescale 1ns / 1ps
`default_nettype none

module equation_token_lexer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [etl_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [31:0] mantissa, [35:32] frac_digits, [36] overflow, [37] last_of_item
    output logic [etl_pkg::DATA_W-1:0]      m_tdata,
    output logic [etl_pkg::KIND_W-1:0]      m_tuser,   // [2:0] token_kind
    output logic                            m_tlast,   // last_of_text
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_data
);
    import etl_pkg::*;

    logic     ml_en_reg, ml_en_next;
    logic     room;
    lex_out_t lex_out;
    tok_t     m_tok;

    assign cfg_ready  = 1'b1;
    assign ml_en_next = cfg_valid ? cfg_data : ml_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ml_en_reg <= 1'b1;
        else
            ml_en_reg <= ml_en_next;
    end

    etl_lex_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .ml_en    (ml_en_reg),
        .room     (room),
        .lex_out  (lex_out)
    );

    etl_tok_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .lex_in   (lex_out),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tok    (m_tok)
    );

    assign m_tuser = m_tok.kind;
    assign m_tlast = m_tok.last_text;
    assign m_tdata = DATA_W'({m_tok.last_item, m_tok.ovf, m_tok.frac, m_tok.mant});

endmodule

`default_nettype wire
